/* hw/rtl/bledit_pkg.sv */
package bledit_pkg;

  // Count width that covers the largest supported capacity.
  localparam int unsigned CntW = 13;

  localparam logic [2:0] FUNC_INS_FRONT = 3'd0;
  localparam logic [2:0] FUNC_INS_MID   = 3'd1;
  localparam logic [2:0] FUNC_INS_BACK  = 3'd2;
  localparam logic [2:0] FUNC_DEL_FRONT = 3'd3;
  localparam logic [2:0] FUNC_DEL_MID   = 3'd4;
  localparam logic [2:0] FUNC_DEL_BACK  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUT_BACK,
    OP_PUT,
    OP_TAKE_BACK,
    OP_TAKE
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [1:0]         status;
    logic [CntW-1:0]    pos;
    logic [CntW-1:0]    len;
    logic signed [31:0] value;
  } cmd_t;

endpackage

/* hw/rtl/bledit_front.sv */
module bledit_front #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] value_i,
  input  logic               full_i,
  output logic               busy_o,
  output logic               push_o,
  output bledit_pkg::cmd_t   cmd_o
);

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] half, mid;
  logic          is_full, is_empty;

  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

  always_comb begin
    half     = count_q >> 1;
    mid      = (half >= CW'(2)) ? (half - CW'(1)) : CW'(1);
    is_full  = (count_q == CW'(CAPACITY));
    is_empty = (count_q == '0);

    cmd_o.op     = bledit_pkg::OP_NONE;
    cmd_o.status = bledit_pkg::ST_OK;
    cmd_o.pos    = '0;
    cmd_o.len    = bledit_pkg::CntW'(count_q);
    cmd_o.value  = value_i;

    case (func_i)
      bledit_pkg::FUNC_INS_FRONT, bledit_pkg::FUNC_INS_MID, bledit_pkg::FUNC_INS_BACK: begin
        if (is_full) begin
          cmd_o.status = bledit_pkg::ST_FULL;
        end else begin
          cmd_o.len = bledit_pkg::CntW'(count_q + CW'(1));
          if (func_i == bledit_pkg::FUNC_INS_BACK) begin
            cmd_o.op = bledit_pkg::OP_PUT_BACK;
          end else begin
            cmd_o.op = bledit_pkg::OP_PUT;
            if (func_i == bledit_pkg::FUNC_INS_MID && !is_empty) begin
              cmd_o.pos = bledit_pkg::CntW'(mid);
            end
          end
        end
      end
      bledit_pkg::FUNC_DEL_FRONT, bledit_pkg::FUNC_DEL_MID, bledit_pkg::FUNC_DEL_BACK: begin
        if (is_empty) begin
          cmd_o.status = bledit_pkg::ST_EMPTY;
        end else begin
          cmd_o.len = bledit_pkg::CntW'(count_q - CW'(1));
          if (func_i == bledit_pkg::FUNC_DEL_BACK) begin
            cmd_o.op = bledit_pkg::OP_TAKE_BACK;
          end else begin
            cmd_o.op = bledit_pkg::OP_TAKE;
            if (func_i == bledit_pkg::FUNC_DEL_MID && count_q != CW'(1)) begin
              cmd_o.pos = bledit_pkg::CntW'(mid);
            end
          end
        end
      end
      default: begin
      end
    endcase

    count_d = push_o ? CW'(cmd_o.len) : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

/* hw/rtl/bledit_queue.sv */
module bledit_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bledit_pkg::cmd_t cmd_i,
  input  logic             pop_i,
  output bledit_pkg::cmd_t cmd_o,
  output logic             empty_o,
  output logic             full_o
);

  bledit_pkg::cmd_t slot_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       used_q;

  assign cmd_o   = slot_q[rd_q];
  assign empty_o = (used_q == 2'd0);
  assign full_o  = (used_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      used_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        used_q <= used_q + 2'd1;
      end else if (pop_i && !push_i) begin
        used_q <= used_q - 2'd1;
      end
    end
  end

endmodule

/* hw/rtl/bledit_back.sv */
module bledit_back #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  bledit_pkg::cmd_t   cmd_i,
  output logic               pop_o,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] removed_o,
  output logic [CW-1:0]      length_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TAKE = 2'd1;
  localparam logic [1:0] S_MOVE = 2'd2;
  localparam logic [1:0] S_PUT  = 2'd3;

  logic signed [31:0] mem [2**AW];
  logic signed [31:0] rdata_q;

  logic [1:0]         state_q, state_d;
  logic [AW-1:0]      head_q, head_d;
  logic [AW-1:0]      rd_addr_q, rd_addr_d;
  logic [CW-1:0]      left_q, left_d;
  logic               dir_q, dir_d;
  bledit_pkg::cmd_t   cur_q, cur_d;
  logic signed [31:0] taken_q, taken_d;

  logic               done_q, done_d;
  logic [1:0]         status_q, status_d;
  logic signed [31:0] removed_q, removed_d;
  logic [CW-1:0]      length_q, length_d;

  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic signed [31:0] wdata;

  assign done_o    = done_q;
  assign status_o  = status_q;
  assign removed_o = removed_q;
  assign length_o  = length_q;

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    rd_addr_d = rd_addr_q;
    left_d    = left_q;
    dir_d     = dir_q;
    cur_d     = cur_q;
    taken_d   = taken_q;
    done_d    = 1'b0;
    status_d  = status_q;
    removed_d = removed_q;
    length_d  = length_q;
    pop_o     = 1'b0;
    we        = 1'b0;
    waddr     = head_q;
    wdata     = cur_q.value;
    re        = 1'b0;
    raddr     = head_q;

    case (state_q)
      S_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          cur_d = cmd_i;
          case (cmd_i.op)
            bledit_pkg::OP_PUT_BACK: begin
              we        = 1'b1;
              waddr     = head_q + AW'(cmd_i.len) - AW'(1);
              wdata     = cmd_i.value;
              done_d    = 1'b1;
              status_d  = bledit_pkg::ST_OK;
              removed_d = '0;
              length_d  = CW'(cmd_i.len);
            end
            bledit_pkg::OP_PUT: begin
              if (cmd_i.pos == '0) begin
                we        = 1'b1;
                waddr     = head_q - AW'(1);
                wdata     = cmd_i.value;
                head_d    = head_q - AW'(1);
                done_d    = 1'b1;
                status_d  = bledit_pkg::ST_OK;
                removed_d = '0;
                length_d  = CW'(cmd_i.len);
              end else begin
                re        = 1'b1;
                raddr     = head_q;
                rd_addr_d = head_q;
                left_d    = CW'(cmd_i.pos) - CW'(1);
                dir_d     = 1'b1;
                state_d   = S_MOVE;
              end
            end
            bledit_pkg::OP_TAKE_BACK: begin
              re      = 1'b1;
              raddr   = head_q + AW'(cmd_i.len);
              state_d = S_TAKE;
            end
            bledit_pkg::OP_TAKE: begin
              re      = 1'b1;
              raddr   = head_q + AW'(cmd_i.pos);
              state_d = S_TAKE;
            end
            default: begin
              done_d    = 1'b1;
              status_d  = cmd_i.status;
              removed_d = '0;
              length_d  = CW'(cmd_i.len);
            end
          endcase
        end
      end
      S_TAKE: begin
        taken_d = rdata_q;
        if (cur_q.op == bledit_pkg::OP_TAKE_BACK || cur_q.pos == '0) begin
          if (cur_q.op == bledit_pkg::OP_TAKE) begin
            head_d = head_q + AW'(1);
          end
          done_d    = 1'b1;
          status_d  = bledit_pkg::ST_OK;
          removed_d = rdata_q;
          length_d  = CW'(cur_q.len);
          state_d   = S_IDLE;
        end else begin
          re        = 1'b1;
          raddr     = head_q + AW'(cur_q.pos) - AW'(1);
          rd_addr_d = raddr;
          left_d    = CW'(cur_q.pos) - CW'(1);
          dir_d     = 1'b0;
          state_d   = S_MOVE;
        end
      end
      S_MOVE: begin
        we    = 1'b1;
        waddr = dir_q ? (rd_addr_q - AW'(1)) : (rd_addr_q + AW'(1));
        wdata = rdata_q;
        if (left_q != '0) begin
          re        = 1'b1;
          raddr     = dir_q ? (rd_addr_q + AW'(1)) : (rd_addr_q - AW'(1));
          rd_addr_d = raddr;
          left_d    = left_q - CW'(1);
        end else if (dir_q) begin
          state_d = S_PUT;
        end else begin
          head_d    = head_q + AW'(1);
          done_d    = 1'b1;
          status_d  = bledit_pkg::ST_OK;
          removed_d = taken_q;
          length_d  = CW'(cur_q.len);
          state_d   = S_IDLE;
        end
      end
      S_PUT: begin
        we        = 1'b1;
        waddr     = head_q - AW'(1) + AW'(cur_q.pos);
        wdata     = cur_q.value;
        head_d    = head_q - AW'(1);
        done_d    = 1'b1;
        status_d  = bledit_pkg::ST_OK;
        removed_d = '0;
        length_d  = CW'(cur_q.len);
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    taken_q   <= taken_d;
    rd_addr_q <= rd_addr_d;
    dir_q     <= dir_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    length_q  <= length_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      left_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      left_q  <= left_d;
      done_q  <= done_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUT |-> $past(state_q) == S_MOVE && dir_q)
    else $error("Final insert write was not preceded by an upward shift.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MOVE && left_q == '0 && !dir_q |=> done_q)
    else $error("Middle delete finished its shift without a result word.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && status_q != bledit_pkg::ST_OK |-> removed_q == '0)
    else $error("Failed edit reports a nonzero removed value.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q != $past(head_q) |-> done_q)
    else $error("List head moved without completing an edit.");

endmodule

/* hw/rtl/bounded_list_end_and_middle_edit.sv */
// Channel   Ports                                       Handshake
// command   func_i, value_i                             start && !busy
// result    status_o, removed_value_o, length_now_o     done_o, one cycle
//
// The front takes a command word per cycle; busy is high only while its two-entry queue is full.
// The back finishes a failed edit, an unused code, an insert at either end or a middle insert
// into an empty list in its idle state; a delete at either end first reads the entry in its take
// state, and any other middle edit shifts the entries ahead of it one memory word a cycle.
// The result word appears the cycle after the back finishes the edit and cannot be held off.
// Reset empties the list at once; the entry memory is not cleared.
module bounded_list_end_and_middle_edit #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] removed_value_o,
  output logic [CW-1:0]      length_now_o
);

  bledit_pkg::cmd_t push_cmd, pop_cmd;
  logic             push, pop, q_empty, q_full;

  bledit_front #(.CAPACITY(CAPACITY)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .func_i (func_i),
    .value_i(value_i),
    .full_i (q_full),
    .busy_o (busy),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  bledit_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (pop_cmd),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  bledit_back #(.CAPACITY(CAPACITY)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (!q_empty),
    .cmd_i    (pop_cmd),
    .pop_o    (pop),
    .done_o   (done_o),
    .status_o (status_o),
    .removed_o(removed_value_o),
    .length_o (length_now_o)
  );

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIST_CAP = 64;
  localparam int unsigned LEN_W = $clog2(LIST_CAP + 1);
  localparam int unsigned RANDOM_WORDS = 1800;
  localparam int unsigned CALM_TAIL = 200;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam logic [2:0] FUNC_SPARE_A = 3'd6;
  localparam logic [2:0] FUNC_SPARE_B = 3'd7;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed;
    logic [LEN_W-1:0]   len;
  } edit_res_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
    logic               typed;
    edit_res_t          res;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         func_i = bledit_pkg::FUNC_INS_FRONT;
  logic signed [31:0] value_i = '0;
  logic               done_o;
  logic [1:0]         status_o;
  logic signed [31:0] removed_value_o;
  logic [LEN_W-1:0]   length_now_o;

  logic signed [31:0] list_model[$];
  edit_res_t          edit_results_due[$];
  int unsigned        mismatches = 0;
  int unsigned        cycles = 0;
  bit                 idle_on = 1'b1;
  bit                 calm = 1'b0;

  stim_row_t directed_rows [0:21] = '{
    '{bledit_pkg::FUNC_DEL_FRONT, 32'sd0, 1'b1, '{bledit_pkg::ST_EMPTY, 32'sd0, 7'd0}},
    '{bledit_pkg::FUNC_DEL_MID, -32'sd1, 1'b1, '{bledit_pkg::ST_EMPTY, 32'sd0, 7'd0}},
    '{bledit_pkg::FUNC_DEL_BACK, 32'sd0, 1'b1, '{bledit_pkg::ST_EMPTY, 32'sd0, 7'd0}},
    '{bledit_pkg::FUNC_INS_MID, VAL_MAX, 1'b1, '{bledit_pkg::ST_OK, 32'sd0, 7'd1}},
    '{bledit_pkg::FUNC_INS_MID, VAL_MIN, 1'b1, '{bledit_pkg::ST_OK, 32'sd0, 7'd2}},
    '{bledit_pkg::FUNC_DEL_MID, 32'sd0, 1'b1, '{bledit_pkg::ST_OK, VAL_MIN, 7'd1}},
    '{bledit_pkg::FUNC_DEL_MID, 32'sd0, 1'b1, '{bledit_pkg::ST_OK, VAL_MAX, 7'd0}},
    '{bledit_pkg::FUNC_INS_FRONT, -32'sd1, 1'b1, '{bledit_pkg::ST_OK, 32'sd0, 7'd1}},
    '{bledit_pkg::FUNC_INS_BACK, 32'sd0, 1'b1, '{bledit_pkg::ST_OK, 32'sd0, 7'd2}},
    '{bledit_pkg::FUNC_INS_FRONT, 32'sh5555_5555, 1'b1, '{bledit_pkg::ST_OK, 32'sd0, 7'd3}},
    '{bledit_pkg::FUNC_INS_BACK, 32'shAAAA_AAAA, 1'b1, '{bledit_pkg::ST_OK, 32'sd0, 7'd4}},
    '{bledit_pkg::FUNC_INS_MID, 32'sd123, 1'b0, '0},
    '{FUNC_SPARE_A, 32'sh1234_5678, 1'b1, '{bledit_pkg::ST_OK, 32'sd0, 7'd5}},
    '{FUNC_SPARE_B, -32'sd1, 1'b1, '{bledit_pkg::ST_OK, 32'sd0, 7'd5}},
    '{bledit_pkg::FUNC_INS_MID, -32'sd77, 1'b0, '0},
    '{bledit_pkg::FUNC_DEL_FRONT, 32'sd0, 1'b0, '0},
    '{bledit_pkg::FUNC_DEL_BACK, -32'sd1, 1'b0, '0},
    '{bledit_pkg::FUNC_DEL_MID, 32'sd0, 1'b0, '0},
    '{bledit_pkg::FUNC_DEL_MID, -32'sd1, 1'b0, '0},
    '{bledit_pkg::FUNC_DEL_FRONT, 32'sd0, 1'b0, '0},
    '{bledit_pkg::FUNC_DEL_BACK, 32'sd0, 1'b0, '0},
    '{bledit_pkg::FUNC_DEL_BACK, VAL_MAX, 1'b1, '{bledit_pkg::ST_EMPTY, 32'sd0, 7'd0}}
  };

  bounded_list_end_and_middle_edit #(
    .CAPACITY(LIST_CAP)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .length_now_o   (length_now_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int unsigned middle_of(input int unsigned n);
    int unsigned half;
    half = n / 2;
    return (half >= 2) ? half - 1 : 1;
  endfunction

  function automatic void apply_edit(input logic [2:0] f, input logic signed [31:0] v,
                                     output edit_res_t r);
    int unsigned pos;
    int unsigned n;
    n = list_model.size();
    r.status = bledit_pkg::ST_OK;
    r.removed = '0;
    case (f)
      bledit_pkg::FUNC_INS_FRONT, bledit_pkg::FUNC_INS_MID, bledit_pkg::FUNC_INS_BACK: begin
        if (n >= LIST_CAP) begin
          r.status = bledit_pkg::ST_FULL;
        end else begin
          if (f == bledit_pkg::FUNC_INS_FRONT) pos = 0;
          else if (f == bledit_pkg::FUNC_INS_BACK) pos = n;
          else pos = (middle_of(n) > n) ? n : middle_of(n);
          list_model.insert(pos, v);
        end
      end
      bledit_pkg::FUNC_DEL_FRONT, bledit_pkg::FUNC_DEL_MID, bledit_pkg::FUNC_DEL_BACK: begin
        if (n == 0) begin
          r.status = bledit_pkg::ST_EMPTY;
        end else begin
          if (f == bledit_pkg::FUNC_DEL_FRONT) pos = 0;
          else if (f == bledit_pkg::FUNC_DEL_BACK) pos = n - 1;
          else pos = (middle_of(n) >= n) ? n - 1 : middle_of(n);
          r.removed = list_model[pos];
          list_model.delete(pos);
        end
      end
      default: ;
    endcase
    r.len = LEN_W'(list_model.size());
  endfunction

  function automatic void compare_field(input string label, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      mismatches++;
    end
  endfunction

  // A word is taken at the edge where start is high and busy is low.
  task automatic issue_word(input logic [2:0] f, input logic signed [31:0] v,
                            input logic typed, input edit_res_t typed_res);
    edit_res_t predicted;
    start <= 1'b1;
    func_i <= f;
    value_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    apply_edit(f, v, predicted);
    edit_results_due.push_back(typed ? typed_res : predicted);
  endtask

  task automatic maybe_pause();
    int unsigned gap;
    if (!calm && idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    edit_res_t want;
    if (rst_ni && done_o) begin
      if (edit_results_due.size() == 0) begin
        $display("%0t: result word with nothing expected, actual %h %h %h", $time,
                 status_o, removed_value_o, length_now_o);
        mismatches++;
      end else begin
        want = edit_results_due.pop_front();
        compare_field("status", 32'(want.status), 32'(status_o));
        compare_field("removed_value", want.removed, removed_value_o);
        compare_field("length_now", 32'(want.len), 32'(length_now_o));
      end
    end
  end

  initial begin
    int unsigned counted;
    int unsigned seg_left;
    int unsigned ins_pct;
    int unsigned roll;
    logic [2:0] f;
    logic signed [31:0] v;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      issue_word(directed_rows[i].func, directed_rows[i].value, directed_rows[i].typed,
                 directed_rows[i].res);
      maybe_pause();
    end

    // Most segments lean toward inserts or deletes so the list swings between
    // empty and full, with middle edits at every length on the way.
    counted = 0;
    seg_left = 0;
    ins_pct = 50;
    while (counted < RANDOM_WORDS) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 90);
        case ($urandom_range(0, 4))
          0: ins_pct = 92;
          1: ins_pct = 8;
          2: ins_pct = 70;
          3: ins_pct = 30;
          default: ins_pct = 50;
        endcase
        idle_on = ($urandom_range(0, 2) != 0);
      end
      seg_left--;
      calm = (counted >= RANDOM_WORDS - CALM_TAIL);
      roll = $urandom_range(0, 99);
      if (roll < 3) f = $urandom_range(0, 1) ? FUNC_SPARE_A : FUNC_SPARE_B;
      else if ($urandom_range(0, 99) < ins_pct) f = 3'($urandom_range(0, 2));
      else f = 3'($urandom_range(3, 5));
      case ($urandom_range(0, 11))
        0: v = VAL_MAX;
        1: v = VAL_MIN;
        2: v = '0;
        3: v = -32'sd1;
        default: v = $urandom;
      endcase
      issue_word(f, v, 1'b0, '0);
      if (f != FUNC_SPARE_A && f != FUNC_SPARE_B) counted++;
      maybe_pause();
    end
    start <= 1'b0;

    while (edit_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && edit_results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
